[hdl/dstat_pkg.sv]
// descriptive statistics: shared types and constants
// used by dstat_ctrl, dstat_datapath and descriptive_statistics_core
`default_nettype none

package dstat_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 24;
  localparam int COUNT_W  = 9;
  localparam int VAR_W    = 32;
  localparam int ROOT_W   = 16;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_MUL_NSQ,
    OP_MUL_MAG,
    OP_MUL_NN,
    OP_DIV_VAR,
    OP_DIV_AVG,
    OP_SQRT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_MUL_NSQ,
    S_MUL_MAG,
    S_MUL_NN,
    S_DIV_VAR,
    S_DIV_AVG,
    S_SQRT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic launch;
    op_t  op;
    logic clear;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/dstat_ctrl.sv]
// descriptive statistics: sequencing state machine
// depends on dstat_pkg; drives dstat_datapath through cmd_t
`default_nettype none

module dstat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last,
  input  logic              op_done,
  output dstat_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done
);
  import dstat_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_EMIT);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept && last) state_next = S_PASS;
      S_PASS:    if (op_done) state_next = S_MUL_NSQ;
      S_MUL_NSQ: if (op_done) state_next = S_MUL_MAG;
      S_MUL_MAG: if (op_done) state_next = S_MUL_NN;
      S_MUL_NN:  if (op_done) state_next = S_DIV_VAR;
      S_DIV_VAR: if (op_done) state_next = S_DIV_AVG;
      S_DIV_AVG: if (op_done) state_next = S_SQRT;
      S_SQRT:    if (op_done) state_next = S_EMIT;
      S_EMIT:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = 1'b0;
    cmd.launch = 1'b0;
    cmd.op     = OP_PASS;
    cmd.clear  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load   = accept;
        cmd.launch = accept && last;
        cmd.op     = OP_PASS;
      end
      S_PASS: begin
        cmd.launch = op_done;
        cmd.op     = OP_MUL_NSQ;
      end
      S_MUL_NSQ: begin
        cmd.launch = op_done;
        cmd.op     = OP_MUL_MAG;
      end
      S_MUL_MAG: begin
        cmd.launch = op_done;
        cmd.op     = OP_MUL_NN;
      end
      S_MUL_NN: begin
        cmd.launch = op_done;
        cmd.op     = OP_DIV_VAR;
      end
      S_DIV_VAR: begin
        cmd.launch = op_done;
        cmd.op     = OP_DIV_AVG;
      end
      S_DIV_AVG: begin
        cmd.launch = op_done;
        cmd.op     = OP_SQRT;
      end
      S_SQRT: begin
        cmd.launch = 1'b0;
      end
      S_EMIT: begin
        cmd.clear = 1'b1;
      end
      default: begin
        cmd.clear = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/dstat_datapath.sv]
// descriptive statistics: sample store, running sums, second pass,
// shift-add multiplier, restoring divider and bit-pair square root; uses dstat_pkg
`default_nettype none

module dstat_datapath #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dstat_pkg::cmd_t                          cmd,
  input  logic signed [dstat_pkg::SAMPLE_W-1:0]    sample,
  output logic                                     op_done,
  output logic        [dstat_pkg::COUNT_W-1:0]     count,
  output logic signed [dstat_pkg::TOTAL_W-1:0]     total,
  output logic signed [dstat_pkg::SAMPLE_W-1:0]    largest,
  output logic signed [dstat_pkg::SAMPLE_W-1:0]    average,
  output logic        [dstat_pkg::VAR_W-1:0]       spread_squared,
  output logic        [dstat_pkg::ROOT_W-1:0]      spread,
  output logic                                     overflowed
);
  import dstat_pkg::*;

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int XSQ_W = 2 * SAMPLE_W - 1;
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int MAG_W = SAMPLE_W - 1 + CW;
  localparam int SQ_W  = 2 * SAMPLE_W - 2 + CW;
  localparam int NUM_W = 2 * SAMPLE_W - 2 + 2 * CW;
  localparam int DEN_W = 2 * CW;
  localparam int DCW   = $clog2(NUM_W + 1);

  // running state
  logic        [CW-1:0]       kept_count;
  logic        [TOTAL_W-1:0]  running_total;
  logic signed [SAMPLE_W-1:0] running_max;
  logic                       drop_flag;
  logic                       full;

  // sample store
  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       wr_en;
  logic                       rd_en;

  // unit control
  logic active;
  op_t  op_q;
  logic fin;
  logic launch_mul;
  logic launch_div;

  // second pass
  logic        [CW-1:0]         idx;
  logic                         rd_valid;
  logic                         sq_valid;
  logic signed [SAMPLE_W-1:0]   x_q;
  logic signed [2*SAMPLE_W-1:0] x_prod;
  logic        [XSQ_W-1:0]      xsq_q;
  logic signed [SUM_W-1:0]      exact_sum;
  logic        [SQ_W-1:0]       sum_sq;
  logic        [SUM_W-1:0]      sum_abs;
  logic        [MAG_W-1:0]      mag;

  // multiplier
  logic [NUM_W-1:0] mul_a;
  logic [MAG_W-1:0] mul_b;
  logic [NUM_W-1:0] mul_p;

  // divider
  logic [NUM_W-1:0]   div_q;
  logic [DEN_W-1:0]   div_r;
  logic [DEN_W-1:0]   div_d;
  logic [DCW-1:0]     div_cnt;
  logic [DEN_W:0]     div_trial;
  logic [DEN_W:0]     div_diff;
  logic               div_ge;
  logic [TOTAL_W-1:0] tot_abs;
  logic               tot_neg;

  // square root
  logic [VAR_W-1:0] sq_v;
  logic [VAR_W-1:0] sq_root;
  logic [VAR_W-1:0] sq_bit;
  logic [VAR_W-1:0] sq_try;

  // results
  logic [NUM_W-1:0]           num;
  logic [DEN_W-1:0]           den;
  logic [VAR_W-1:0]           var_q;
  logic signed [SAMPLE_W-1:0] avg_q;
  logic [ROOT_W-1:0]          root_q;

  assign full  = (kept_count == CW'(MAX_SAMPLES));
  assign wr_en = cmd.load && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count    <= '0;
      running_total <= '0;
      running_max   <= '0;
      drop_flag     <= 1'b0;
    end else if (cmd.clear) begin
      kept_count    <= '0;
      running_total <= '0;
      running_max   <= '0;
      drop_flag     <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        drop_flag <= 1'b1;
      end else begin
        kept_count    <= kept_count + 1'b1;
        running_total <= running_total + {{(TOTAL_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
        if (kept_count == '0 || sample > running_max) begin
          running_max <= sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[kept_count[AW-1:0]] <= sample;
    end
    if (rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  // unit sequencing
  always_comb begin
    fin = 1'b0;
    if (active) begin
      case (op_q)
        OP_PASS:    fin = (idx == kept_count) && !rd_valid && !sq_valid;
        OP_MUL_NSQ: fin = (mul_b == '0);
        OP_MUL_MAG: fin = (mul_b == '0);
        OP_MUL_NN:  fin = (mul_b == '0);
        OP_DIV_VAR: fin = (div_cnt == '0);
        OP_DIV_AVG: fin = (div_cnt == '0);
        OP_SQRT:    fin = (sq_bit == '0);
        default:    fin = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      op_q    <= OP_PASS;
      op_done <= 1'b0;
    end else begin
      op_done <= fin;
      if (cmd.launch) begin
        active <= 1'b1;
        op_q   <= cmd.op;
      end else if (fin) begin
        active <= 1'b0;
      end
    end
  end

  // second pass over the store
  assign rd_en  = active && (op_q == OP_PASS) && (idx != kept_count);
  assign x_prod = rd_data * rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else if (cmd.launch && cmd.op == OP_PASS) begin
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      sq_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_q   <= rd_data;
    xsq_q <= x_prod[XSQ_W-1:0];
    if (cmd.launch && cmd.op == OP_PASS) begin
      idx       <= '0;
      exact_sum <= '0;
      sum_sq    <= '0;
    end else begin
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (sq_valid) begin
        exact_sum <= exact_sum + SUM_W'(x_q);
        sum_sq    <= sum_sq + SQ_W'(xsq_q);
      end
    end
  end

  assign sum_abs = exact_sum[SUM_W-1] ? SUM_W'(-exact_sum) : SUM_W'(exact_sum);
  assign mag     = sum_abs[MAG_W-1:0];

  // shift-add multiplier
  assign launch_mul = cmd.launch &&
                      (cmd.op == OP_MUL_NSQ || cmd.op == OP_MUL_MAG || cmd.op == OP_MUL_NN);

  always_ff @(posedge clk) begin
    if (launch_mul) begin
      mul_p <= '0;
      case (cmd.op)
        OP_MUL_NSQ: begin
          mul_a <= NUM_W'(sum_sq);
          mul_b <= MAG_W'(kept_count);
        end
        OP_MUL_MAG: begin
          mul_a <= NUM_W'(mag);
          mul_b <= mag;
        end
        default: begin
          mul_a <= NUM_W'(kept_count);
          mul_b <= MAG_W'(kept_count);
        end
      endcase
    end else if (mul_b != '0) begin
      if (mul_b[0]) begin
        mul_p <= mul_p + mul_a;
      end
      mul_a <= mul_a << 1;
      mul_b <= mul_b >> 1;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign tot_neg    = running_total[TOTAL_W-1];
  assign tot_abs    = tot_neg ? (~running_total + 1'b1) : running_total;
  assign launch_div = cmd.launch && (cmd.op == OP_DIV_VAR || cmd.op == OP_DIV_AVG);
  assign div_trial  = {div_r, div_q[NUM_W-1]};
  assign div_ge     = (div_trial >= {1'b0, div_d});
  assign div_diff   = div_trial - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (launch_div) begin
      div_cnt <= DCW'(NUM_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (launch_div) begin
      div_r <= '0;
      if (cmd.op == OP_DIV_VAR) begin
        div_q <= num;
        div_d <= den;
      end else begin
        div_q <= NUM_W'(tot_abs);
        div_d <= DEN_W'(kept_count);
      end
    end else if (div_cnt != '0) begin
      div_r <= div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
      div_q <= {div_q[NUM_W-2:0], div_ge};
    end
  end

  // square root, one result bit per cycle
  assign sq_try = sq_root + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_bit <= '0;
    end else if (cmd.launch && cmd.op == OP_SQRT) begin
      sq_bit <= VAR_W'(1) << (VAR_W - 2);
    end else if (sq_bit != '0) begin
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.launch && cmd.op == OP_SQRT) begin
      sq_v    <= var_q;
      sq_root <= '0;
    end else if (sq_bit != '0) begin
      if (sq_v >= sq_try) begin
        sq_v    <= sq_v - sq_try;
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (fin) begin
      case (op_q)
        OP_MUL_NSQ: num <= mul_p;
        OP_MUL_MAG: num <= num - mul_p;
        OP_MUL_NN:  den <= mul_p[DEN_W-1:0];
        OP_DIV_VAR: var_q <= (|div_q[NUM_W-1:VAR_W]) ? '1 : div_q[VAR_W-1:0];
        OP_DIV_AVG: avg_q <= tot_neg ? SAMPLE_W'(~div_q[SAMPLE_W-1:0] + 1'b1)
                                     : div_q[SAMPLE_W-1:0];
        OP_SQRT:    root_q <= sq_root[ROOT_W-1:0];
        default:    root_q <= root_q;
      endcase
    end
  end

  assign count          = COUNT_W'(kept_count);
  assign total          = running_total;
  assign largest        = running_max;
  assign average        = avg_q;
  assign spread_squared = var_q;
  assign spread         = root_q;
  assign overflowed     = drop_flag;

endmodule

`default_nettype wire

[hdl/descriptive_statistics_core.sv]
// descriptive statistics top level: count, sum, max, mean, variance, std dev
// depends on dstat_pkg, dstat_ctrl and dstat_datapath
//
//   port group        dir   width            when
//   start / busy      in    sample, last     beat taken when start && !busy
//   done              out   count .. overflowed  one-cycle strobe per closed set
//
// one sample beat per cycle while a set is loading; busy stays low until the
// beat marked last. then busy is high through the second pass over the store,
// three shift-add products, two restoring divider runs of 30 + 2*CW steps each,
// 16 root steps and the done cycle (CW = bits to hold MAX_SAMPLES).
// done lasts one cycle and cannot be held off; state clears on synchronous rst.
`default_nettype none

module descriptive_statistics_core #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [dstat_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  last,
  output logic                                  done,
  output logic        [dstat_pkg::COUNT_W-1:0]  count,
  output logic signed [dstat_pkg::TOTAL_W-1:0]  total,
  output logic signed [dstat_pkg::SAMPLE_W-1:0] largest,
  output logic signed [dstat_pkg::SAMPLE_W-1:0] average,
  output logic        [dstat_pkg::VAR_W-1:0]    spread_squared,
  output logic        [dstat_pkg::ROOT_W-1:0]   spread,
  output logic                                  overflowed
);
  import dstat_pkg::*;

  cmd_t cmd;
  logic op_done;

  dstat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last    (last),
    .op_done (op_done),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  dstat_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sample         (sample),
    .op_done        (op_done),
    .count          (count),
    .total          (total),
    .largest        (largest),
    .average        (average),
    .spread_squared (spread_squared),
    .spread         (spread),
    .overflowed     (overflowed)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("closing beat did not start processing");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("sample loaded while busy");

endmodule

`default_nettype wire
